/* hw/rtl/srad_pkg.sv */
// Shared types and constants for the sequential read-ahead detector.
// Used by srad_ctrl, srad_datapath and the top level; depends on nothing.
`default_nettype none

package srad_pkg;

  localparam int unsigned FILE_W    = 64;
  localparam int unsigned VOL_W     = 32;
  localparam int unsigned OFF_W     = 64;
  localparam int unsigned PAGE_W    = 52;
  localparam int unsigned RUN_W     = 8;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned HASH_W    = 32;
  localparam int unsigned HASH_FOLD = 10;

  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_WARMUP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST  = 8'd1;

  localparam logic [RUN_W-1:0]   WARMUP_RESET = 8'd1;
  localparam logic [COUNT_W-1:0] BURST_RESET  = 4'd4;
  localparam logic [RUN_W-1:0]   RUN_MAX      = 8'd255;

  typedef struct packed {
    logic [FILE_W-1:0] file;
    logic [VOL_W-1:0]  volume;
    logic [PAGE_W-1:0] next_page;
    logic [RUN_W-1:0]  run;
  } stream_entry_t;

  typedef struct packed {
    logic clr_en;
    logic capture;
    logic hash_en;
    logic mul1_en;
    logic mul2_en;
    logic mod_en;
    logic rd_en;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

/* hw/rtl/srad_ctrl.sv */
// Controller state machine of the read-ahead detector: clearing pass, input
// beat acceptance and sequencing of the datapath steps. Depends on srad_pkg.
`default_nettype none

module srad_ctrl (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  srad_pkg::ctrl_sts_t  sts_i,
  output srad_pkg::ctrl_cmd_t  cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_MUL1  = 3'd3;
  localparam logic [2:0] ST_MUL2  = 3'd4;
  localparam logic [2:0] ST_MOD   = 3'd5;
  localparam logic [2:0] ST_READ  = 3'd6;
  localparam logic [2:0] ST_EVAL  = 3'd7;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_en = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_HASH;
        end
      end
      ST_HASH: begin
        cmd_o.hash_en = 1'b1;
        state_d       = ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul1_en = 1'b1;
        state_d       = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2_en = 1'b1;
        state_d       = ST_MOD;
      end
      ST_MOD: begin
        cmd_o.mod_en = 1'b1;
        state_d      = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_EVAL;
      end
      ST_EVAL: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

endmodule

`default_nettype wire

/* hw/rtl/srad_datapath.sv */
// Datapath of the read-ahead detector: configuration registers, hash and
// slot reduction, end-of-file clipping, cursor table and output register.
// Depends on srad_pkg; driven by srad_ctrl commands.
`default_nettype none

module srad_datapath #(
  parameter int unsigned STREAM_ENTRIES = 256,
  parameter int unsigned PAGE_SHIFT     = 12
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  srad_pkg::ctrl_cmd_t                  cmd_i,
  output srad_pkg::ctrl_sts_t                  sts_o,
  input  wire                                  cfg_valid_i,
  input  wire  [srad_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [srad_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire  [srad_pkg::FILE_W-1:0]          file_id_i,
  input  wire  [srad_pkg::VOL_W-1:0]           volume_id_i,
  input  wire  [srad_pkg::OFF_W-1:0]           byte_offset_i,
  input  wire  [srad_pkg::OFF_W-1:0]           file_bytes_i,
  input  wire                                  was_hit_i,
  input  wire                                  eligible_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic                                 start_burst_o,
  output logic [srad_pkg::PAGE_W-1:0]          first_page_o,
  output logic [srad_pkg::COUNT_W-1:0]         page_count_o
);

  localparam int unsigned IDX_W = (STREAM_ENTRIES > 1) ? $clog2(STREAM_ENTRIES) : 1;
  localparam int unsigned PG_W  = srad_pkg::OFF_W - PAGE_SHIFT;
  localparam logic [63:0] RECIP_W = 64'h1_0000_0000 / 64'(STREAM_ENTRIES);
  localparam logic [srad_pkg::HASH_W-1:0] RECIP = RECIP_W[srad_pkg::HASH_W-1:0];
  localparam logic [srad_pkg::HASH_W-1:0] ENTRIES_H = srad_pkg::HASH_W'(STREAM_ENTRIES);
  localparam logic [IDX_W:0]   ENTRIES_R = (IDX_W+1)'(STREAM_ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(STREAM_ENTRIES - 1);

  // configuration
  logic [srad_pkg::RUN_W-1:0]   warmup_q;
  logic [srad_pkg::COUNT_W-1:0] burst_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      warmup_q <= srad_pkg::WARMUP_RESET;
      burst_q  <= srad_pkg::BURST_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == srad_pkg::CFG_WARMUP) begin
        warmup_q <= cfg_data_i[srad_pkg::RUN_W-1:0];
      end else if (cfg_index_i == srad_pkg::CFG_BURST) begin
        burst_q <= cfg_data_i[srad_pkg::COUNT_W-1:0];
      end
    end
  end

  // clearing pass counter
  logic [IDX_W-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_en) begin
      clr_cnt_q <= clr_cnt_q + IDX_W'(1);
    end
  end

  // captured beat
  logic [srad_pkg::FILE_W-1:0] fid_q;
  logic [srad_pkg::VOL_W-1:0]  vid_q;
  logic [srad_pkg::OFF_W-1:0]  off_q;
  logic [srad_pkg::OFF_W-1:0]  size_q;
  logic                        hit_q;
  logic                        ok_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      fid_q  <= file_id_i;
      vid_q  <= volume_id_i;
      off_q  <= byte_offset_i;
      size_q <= file_bytes_i;
      hit_q  <= was_hit_i;
      ok_q   <= eligible_i;
    end
  end

  // hash fold and page numbers
  logic [srad_pkg::HASH_W-1:0] h_pre, h_q;
  logic [srad_pkg::OFF_W-1:0]  pg_full, last_full;
  logic [PG_W-1:0]             page_q, last_q;
  logic                        size_zero_q;

  assign h_pre     = fid_q[31:0] ^ fid_q[63:32] ^ vid_q;
  assign pg_full   = off_q >> PAGE_SHIFT;
  assign last_full = (size_q - 64'd1) >> PAGE_SHIFT;

  always_ff @(posedge clk_i) begin
    if (cmd_i.hash_en) begin
      h_q         <= h_pre ^ (h_pre >> srad_pkg::HASH_FOLD);
      page_q      <= pg_full[PG_W-1:0];
      last_q      <= last_full[PG_W-1:0];
      size_zero_q <= (size_q == 64'd0);
    end
  end

  // reciprocal quotient estimate, next page, room to end of file
  logic [2*srad_pkg::HASH_W-1:0] prod1;
  logic [srad_pkg::HASH_W-1:0]   quo_q;
  logic [srad_pkg::OFF_W-1:0]    page_ext;
  logic [srad_pkg::PAGE_W-1:0]   first_q;
  logic [PG_W-1:0]               avail_q;
  logic                          room_q;

  assign prod1    = (2*srad_pkg::HASH_W)'(h_q) * (2*srad_pkg::HASH_W)'(RECIP);
  assign page_ext = srad_pkg::OFF_W'(page_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1_en) begin
      quo_q   <= prod1[2*srad_pkg::HASH_W-1:srad_pkg::HASH_W];
      first_q <= page_ext[srad_pkg::PAGE_W-1:0] + srad_pkg::PAGE_W'(1);
      avail_q <= last_q - page_q;
      room_q  <= !size_zero_q && (last_q > page_q);
    end
  end

  // partial remainder and clipped count
  logic [srad_pkg::HASH_W-1:0]  prod2, rem_full;
  logic [IDX_W:0]               rem_q;
  logic [PG_W-1:0]              limit_ext;
  logic [srad_pkg::COUNT_W-1:0] cnt_q;

  assign prod2     = quo_q * ENTRIES_H;
  assign rem_full  = h_q - prod2;
  assign limit_ext = PG_W'(burst_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul2_en) begin
      rem_q <= rem_full[IDX_W:0];
      if (!room_q) begin
        cnt_q <= '0;
      end else if (avail_q < limit_ext) begin
        cnt_q <= avail_q[srad_pkg::COUNT_W-1:0];
      end else begin
        cnt_q <= burst_q;
      end
    end
  end

  // final correction of the slot
  logic [IDX_W:0]   rem_fix;
  logic [IDX_W-1:0] slot_q;

  assign rem_fix = (rem_q >= ENTRIES_R) ? (rem_q - ENTRIES_R) : rem_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_en) begin
      slot_q <= rem_fix[IDX_W-1:0];
    end
  end

  // cursor table
  srad_pkg::stream_entry_t mem [STREAM_ENTRIES];
  srad_pkg::stream_entry_t rd_q, wr_data, wr_next;
  logic [IDX_W-1:0]        wr_addr;
  logic                    wr_en;

  logic                         seq, grant, upd;
  logic [srad_pkg::RUN_W-1:0]   run_inc;

  assign seq = (rd_q.file == fid_q) && (rd_q.volume == vid_q) &&
               (rd_q.next_page == page_ext[srad_pkg::PAGE_W-1:0]);
  assign run_inc = (rd_q.run == srad_pkg::RUN_MAX) ? rd_q.run
                                                   : rd_q.run + srad_pkg::RUN_W'(1);
  assign grant = ok_q && !hit_q && seq && (run_inc >= warmup_q);
  assign upd   = ok_q && (seq || !hit_q);

  always_comb begin
    wr_next.file      = fid_q;
    wr_next.volume    = vid_q;
    wr_next.next_page = first_q;
    if (!seq) begin
      wr_next.run = '0;
    end else if (hit_q) begin
      wr_next.run = rd_q.run;
    end else begin
      wr_next.run = run_inc;
    end
  end

  assign wr_en   = cmd_i.clr_en || (cmd_i.commit && upd);
  assign wr_addr = cmd_i.clr_en ? clr_cnt_q : slot_q;
  assign wr_data = cmd_i.clr_en ? '0 : wr_next;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[slot_q];
    end
  end

  // output register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      start_burst_o <= grant;
      first_page_o  <= grant ? first_q : '0;
      page_count_o  <= grant ? cnt_q : '0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;
  assign sts_o.clr_last = (clr_cnt_q == LAST_IDX);

endmodule

`default_nettype wire

/* hw/rtl/sequential_readahead_detector.sv */
// Sequential read-ahead stream detector, top level.
// Joins srad_ctrl and srad_datapath; depends on srad_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one page-cache lookup per
//   beat; output channel (out_valid_o / out_stall_i) returns exactly one
//   result beat per lookup, in order. A beat moves when valid is high and
//   stall is low.
//   Configuration channel (cfg_valid_i / cfg_ready_o) writes warm-up misses
//   (index 0) and burst pages (index 1); ready is always high, other indexes
//   are dropped. Write only while no lookup is in flight.
//   Steps: an accepted lookup passes the hash fold, the two multiplies of the
//   reciprocal slot reduction, the correction step, the registered table
//   read and the table write, which also loads the output register. One
//   lookup is in flight at a time; the next is taken after the table write.
//   A stalled receiver holds the result in the output register; the block
//   then waits in its last step and takes no new lookup until the result
//   can be loaded.
//   Reset: after rst_ni rises a clearing pass writes zeros to all
//   STREAM_ENTRIES cursors, one per cycle, with in_stall_o high throughout.
`default_nettype none

module sequential_readahead_detector #(
  parameter int unsigned STREAM_ENTRIES = 256,
  parameter int unsigned PAGE_SHIFT     = 12
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [srad_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [srad_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire                                  in_valid_i,
  output logic                                 in_stall_o,
  input  wire  [srad_pkg::FILE_W-1:0]          file_id_i,
  input  wire  [srad_pkg::VOL_W-1:0]           volume_id_i,
  input  wire  [srad_pkg::OFF_W-1:0]           byte_offset_i,
  input  wire  [srad_pkg::OFF_W-1:0]           file_bytes_i,
  input  wire                                  was_hit_i,
  input  wire                                  eligible_i,
  output logic                                 out_valid_o,
  input  wire                                  out_stall_i,
  output logic                                 start_burst_o,
  output logic [srad_pkg::PAGE_W-1:0]          first_page_o,
  output logic [srad_pkg::COUNT_W-1:0]         page_count_o
);

  srad_pkg::ctrl_cmd_t cmd;
  srad_pkg::ctrl_sts_t sts;

  assign cfg_ready_o = 1'b1;

  srad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  srad_datapath #(
    .STREAM_ENTRIES (STREAM_ENTRIES),
    .PAGE_SHIFT     (PAGE_SHIFT)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .file_id_i     (file_id_i),
    .volume_id_i   (volume_id_i),
    .byte_offset_i (byte_offset_i),
    .file_bytes_i  (file_bytes_i),
    .was_hit_i     (was_hit_i),
    .eligible_i    (eligible_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .start_burst_o (start_burst_o),
    .first_page_o  (first_page_o),
    .page_count_o  (page_count_o)
  );

endmodule

`default_nettype wire
